### rtl/core/rcfd_pkg.sv
`timescale 1ns / 1ps
package rcfd_pkg;
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;
  localparam logic [7:0] FRAME_HDR = 8'hA8;
  localparam logic [7:0] STAT_LIVE = 8'h00;
  localparam logic [7:0] STAT_LIVE_ALT = 8'h01;
  localparam logic [7:0] STAT_FAILSAFE = 8'h81;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [1:0] REG_PROTOCOL = 2'd0;
  localparam logic [1:0] REG_GAP = 2'd1;
  localparam logic [1:0] REG_FAILSAFE = 2'd2;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [13:0] scale_word(input logic [15:0] w);
    logic [18:0] s;
    s = ({3'b000, w} + {1'b0, w, 2'b00}) >> 5;
    return (s > 19'd375) ? 14'(s - 19'd375) : 14'd0;
  endfunction
endpackage

### rtl/core/rcfd_chan_mem.sv
`timescale 1ns / 1ps
module rcfd_chan_mem #(
  parameter int Depth = 32,
  parameter int AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);
  logic [15:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/rc_serial_frame_decoder.sv
`timescale 1ns / 1ps
// Byte, tick and read words are taken one at a time. A byte that ends a frame
// walks the buffer memory one byte a cycle for the check; a rejected frame, or a
// failsafe frame before link, is answered once the check is done. An accepted
// frame then walks the channel words and writes every stored channel.
// Channel state is held as epoch-free entries: a timeout, or a failsafe frame
// before link, sets a global "all timed out" flag instead of a clearing pass.
module rc_serial_frame_decoder #(
  parameter int MAX_FRAME_CHANNELS = 32,
  parameter int STORED_CHANNELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  channel_index_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] channel_value_o,
  output logic [1:0]  channel_status_o,
  output logic [6:0]  quality_o,
  output logic [1:0]  frame_event_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import rcfd_pkg::*;
  localparam int Depth = 5 + 2 * MAX_FRAME_CHANNELS;
  localparam int BW = $clog2(Depth + 1);
  localparam int CW = (STORED_CHANNELS > 1) ? $clog2(STORED_CHANNELS) : 1;
  localparam int CCW = $clog2(STORED_CHANNELS + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_OUT = 4'd2,
    S_CHK = 4'd3, S_CHKD = 4'd4, S_DEC = 4'd5, S_WR = 4'd6, S_WAIT = 4'd7;

  logic [3:0] st_q, st_d;
  logic protocol_q; logic [7:0] gap_q, fs_q;
  logic [BW-1:0] bidx_q;
  logic [8:0] exp_q;
  logic capt_q, linked_q, allto_q;
  logic [7:0] quiet_q, good_q;
  logic [14:0] qavg_q;
  logic [13:0] val_q; logic [1:0] stat_q, ev_q;
  logic [7:0] chidx_q;

  // frame buffer
  logic [7:0] fb_mem [Depth];
  logic fb_we; logic [BW-1:0] fb_wa, fb_ra; logic [7:0] fb_rd;
  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_wa] <= rx_byte_i;
    fb_rd <= fb_mem[fb_ra];
  end

  logic cm_we; logic [CW-1:0] cm_wa, cm_ra; logic [15:0] cm_wd, cm_rd;
  rcfd_chan_mem #(.Depth(STORED_CHANNELS), .AW(CW)) u_chan (
    .clk_i, .we_i(cm_we), .waddr_i(cm_wa), .wdata_i(cm_wd),
    .raddr_i(cm_ra), .rdata_o(cm_rd));

  // check / decode walk
  logic [BW-1:0] ptr_q;      // address issued
  logic rdv_q;               // fb_rd valid for byte at ptr_q-1
  logic [BW-1:0] rpos_q;     // position of byte in fb_rd
  logic [15:0] crc_q; logic [7:0] sum_q, b0_q, b1_q, n_q, last1_q, last2_q, hi_q;
  logic [CCW-1:0] wch_q;

  logic [BW-1:0] len_b;
  assign len_b = BW'(exp_q);

  logic in_acc;
  assign in_stall = (st_q != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (st_q == S_OUT);

  logic frame_ok;
  logic stat_ok;
  assign stat_ok = (b1_q == STAT_LIVE) || (b1_q == STAT_LIVE_ALT) || (b1_q == STAT_FAILSAFE);
  assign frame_ok = (b0_q == FRAME_HDR) && stat_ok &&
    (protocol_q ? (sum_q == last1_q) : (crc_q == {last2_q, last1_q}));

  logic [8:0] quiet_inc, good_inc;
  assign quiet_inc = {1'b0, quiet_q} + 9'd1;
  assign good_inc = {1'b0, good_q} + 9'd1;

  // x / 20 as (x >> 2) / 5, exact for x below 2^20
  logic [19:0] q_num;
  logic [14:0] q_new;
  logic [17:0] q_div4;
  logic [33:0] q_prod;
  always_comb begin
    q_num = 20'(qavg_q) * 20'd19 + (frame_ok ? 20'd25600 : 20'd0);
    q_div4 = q_num[19:2];
    q_prod = 34'(q_div4) * 34'd52429;
    q_new = 15'(q_prod >> 18);
  end

  // per-channel entries collected while decoding, written in S_WR
  logic [15:0] cw_q [STORED_CHANNELS];

  always_comb begin
    fb_we = 1'b0; fb_wa = bidx_q[BW-1:0]; fb_ra = ptr_q;
    cm_we = 1'b0; cm_wa = wch_q[CW-1:0];
    cm_wd = cw_q[wch_q[CW-1:0]];
    cm_ra = chidx_q[CW-1:0];
    if (st_q == S_IDLE && in_acc && op_i == OP_BYTE && capt_q && 32'(bidx_q) < Depth)
      fb_we = 1'b1;
    if (st_q == S_WR && 32'(wch_q) < STORED_CHANNELS) cm_we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; protocol_q <= 1'b0; gap_q <= 8'd4; fs_q <= 8'd64;
      bidx_q <= '0; exp_q <= 9'(Depth); capt_q <= 1'b0; linked_q <= 1'b0;
      allto_q <= 1'b1; quiet_q <= '0; good_q <= '0; qavg_q <= '0;
      ptr_q <= '0; rdv_q <= 1'b0; wch_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_PROTOCOL) protocol_q <= cfg_data_i[0];
        else if (cfg_index_i == REG_GAP) gap_q <= cfg_data_i;
        else if (cfg_index_i == REG_FAILSAFE) fs_q <= cfg_data_i;
      end
      unique case (st_q)
        S_IDLE: if (in_acc) begin
          val_q <= '0; stat_q <= ST_VALID; ev_q <= EV_NONE; chidx_q <= channel_index_i;
          st_q <= S_OUT;
          if (op_i == OP_BYTE) begin
            quiet_q <= '0;
            if (capt_q && 32'(bidx_q) < Depth) begin
              bidx_q <= bidx_q + 1'b1;
              if (bidx_q == BW'(2)) begin
                exp_q <= 9'd5 + {rx_byte_i, 1'b0};
                if (9'd5 + {rx_byte_i, 1'b0} == 9'd3) st_q <= S_OUT;
              end else if (9'(bidx_q) + 9'd1 == exp_q) begin
                ptr_q <= '0; rdv_q <= 1'b0; crc_q <= '0; sum_q <= '0;
                st_q <= S_CHK;
              end
            end
          end else if (op_i == OP_TICK) begin
            if (quiet_inc > {1'b0, gap_q}) begin
              capt_q <= 1'b1; bidx_q <= '0; quiet_q <= '0; exp_q <= 9'(Depth);
            end else quiet_q <= quiet_inc[7:0];
            if (good_inc > {1'b0, fs_q}) begin
              good_q <= '0; linked_q <= 1'b0; qavg_q <= '0; allto_q <= 1'b1;
            end else good_q <= good_inc[7:0];
          end else if (op_i == OP_READ) begin
            if (32'(channel_index_i) < STORED_CHANNELS) st_q <= S_READ;
            else stat_q <= ST_NONE;
          end
        end
        S_READ: st_q <= S_WAIT;
        S_WAIT: begin
          if (allto_q) stat_q <= ST_TIMEOUT;
          else begin
            stat_q <= cm_rd[15:14];
            val_q <= (cm_rd[15:14] == ST_VALID) ? cm_rd[13:0] : 14'd0;
          end
          st_q <= S_OUT;
        end
        S_CHK: begin
          if (ptr_q < len_b) ptr_q <= ptr_q + 1'b1;
          rdv_q <= (ptr_q < len_b);
          rpos_q <= ptr_q;
          if (rdv_q) begin
            if (rpos_q == '0) b0_q <= fb_rd;
            if (rpos_q == BW'(1)) b1_q <= fb_rd;
            if (rpos_q == BW'(2)) n_q <= fb_rd;
            if (rpos_q + BW'(2) < len_b) crc_q <= crc_byte(crc_q, fb_rd);
            if (rpos_q + BW'(1) < len_b) sum_q <= sum_q + fb_rd;
            if (rpos_q + BW'(2) == len_b) last2_q <= fb_rd;
            if (rpos_q + BW'(1) == len_b) begin
              last1_q <= fb_rd; st_q <= S_CHKD;
            end
          end
        end
        S_CHKD: begin
          capt_q <= 1'b0;
          qavg_q <= q_new;
          ev_q <= frame_ok ? EV_ACCEPT : EV_REJECT;
          st_q <= S_OUT;
          if (frame_ok) begin
            good_q <= '0;
            if (b1_q != STAT_FAILSAFE) linked_q <= 1'b1;
            if (b1_q == STAT_FAILSAFE && !linked_q) allto_q <= 1'b1;
            else begin
              ptr_q <= BW'(3); rdv_q <= 1'b0; st_q <= S_DEC;
              for (int i = 0; i < STORED_CHANNELS; i++) cw_q[i] <= {ST_NONE, 14'd0};
            end
          end
        end
        S_DEC: begin
          if (ptr_q < len_b) ptr_q <= ptr_q + 1'b1;
          rdv_q <= (ptr_q < len_b);
          rpos_q <= ptr_q;
          if (rdv_q) begin
            if (rpos_q[0]) hi_q <= fb_rd;
            else if (32'((rpos_q - BW'(4)) >> 1) < STORED_CHANNELS &&
                     8'((rpos_q - BW'(4)) >> 1) < n_q)
              cw_q[CW'((rpos_q - BW'(4)) >> 1)] <= {ST_VALID, scale_word({hi_q, fb_rd})};
          end
          if (rdv_q && rpos_q + BW'(1) >= len_b || !rdv_q && ptr_q >= len_b) begin
            st_q <= S_WR; wch_q <= '0;
          end
        end
        S_WR: begin
          if (32'(wch_q) + 1 >= STORED_CHANNELS) begin
            allto_q <= 1'b0; st_q <= S_OUT;
          end
          wch_q <= wch_q + 1'b1;
        end
        S_OUT: if (!out_stall) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign channel_value_o = val_q;
  assign channel_status_o = stat_q;
  assign frame_event_o = ev_q;
  assign quality_o = 7'((16'(qavg_q) + 16'd128) >> 8);

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(frame_event_o)) else $error("result lost");
  a_qual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qavg_q <= 15'd25600) else $error("quality overflow");
endmodule
